### sv/lcp_pkg.sv
`default_nettype none

package lcp_pkg;

  // fixed field widths
  localparam int THR_W       = 12;
  localparam int GAIN_W      = 16;
  localparam int ERR_W       = 13;
  localparam int DERIV_W     = 14;
  localparam int INTEG_W     = 16;
  localparam int ADJ_W       = 34;
  localparam int PROD_W      = 33;
  localparam int CMP_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_PAD_W   = 1;
  localparam int OUT_TDATA_W = ADJ_W + ERR_W + OUT_PAD_W;

  // arithmetic constants
  localparam int WEIGHT_STEP = 1000;
  localparam int LINE_GOAL   = 5000;

  localparam logic [THR_W-1:0] THR_RESET = 12'd2048;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 8'd0,
    REG_GAIN_P    = 8'd1,
    REG_GAIN_I    = 8'd2,
    REG_GAIN_D    = 8'd3
  } cfg_reg_t;

  // multiply sequence: three products, then a final accumulate
  typedef enum logic [1:0] {
    TERM_P   = 2'd0,
    TERM_D   = 2'd1,
    TERM_I   = 2'd2,
    TERM_ACC = 2'd3
  } mul_term_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_MUL,
    S_FIN
  } lcp_state_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      div_init;
    logic      div_step;
    logic      update;
    logic      mul;
    mul_term_t term;
    logic      fin;
  } lcp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_full;
  } lcp_stat_t;

endpackage

`default_nettype wire

### sv/line_centroid_pid.sv
// one scan at a time: a beat is taken in idle, then the scan, the restoring divide, the
//   error update and the multiply steps run and the result is registered; with no sensor
//   on the line it goes from the scan straight to the result. It uses a one-sensor-per-cycle
//   scan, a one-bit-per-cycle restoring divider and one multiplier shared by three products
// reset: synchronous; threshold returns to 2048, gains, integral and previous error to zero
`default_nettype none

module line_centroid_pid #(
  parameter int NUM_SENSORS = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // sample_0 .. sample_N-1, SAMPLE_BITS each, zero pad to bytes
  input  wire [((NUM_SENSORS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // drive_adjust [33:0], position_error [46:34], one zero bit
  output logic [lcp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // no_line
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [lcp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [lcp_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import lcp_pkg::*;

  localparam int IN_TW = ((NUM_SENSORS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int SUM_W = $clog2(WEIGHT_STEP * NUM_SENSORS * (NUM_SENSORS + 1) / 2 + 1);
  localparam int CNT_W = $clog2(NUM_SENSORS + 1);

  lcp_cmd_t  cmd;
  lcp_stat_t stat;

  assign cfg_ready = 1'b1;

  lcp_ctrl #(
    .NUM_SENSORS(NUM_SENSORS),
    .DIV_STEPS  (SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_ready(m_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcp_dpath #(
    .NUM_SENSORS(NUM_SENSORS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IN_TW      (IN_TW),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

endmodule

`default_nettype wire

### sv/lcp_dpath.sv
`default_nettype none

module lcp_dpath #(
  parameter int NUM_SENSORS = 9,
  parameter int SAMPLE_BITS = 12,
  parameter int IN_TW       = 112,
  parameter int SUM_W       = 16,
  parameter int CNT_W       = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_valid,
  input  wire [lcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [lcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire [IN_TW-1:0]                   in_data,
  input  wire lcp_pkg::lcp_cmd_t            cmd,
  output lcp_pkg::lcp_stat_t                stat,
  input  wire                               out_ready,
  output logic                              out_valid,
  output logic [lcp_pkg::OUT_TDATA_W-1:0]   out_data,
  output logic                              out_user
);
  import lcp_pkg::*;

  localparam int IN_W = NUM_SENSORS * SAMPLE_BITS;

  // configuration registers
  logic [THR_W-1:0]  thr;
  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;

  // scan and divide
  logic [IN_W-1:0]  shreg;
  logic [SUM_W-1:0] weight;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rem;
  logic [SUM_W-1:0] quo;

  // control state and products
  logic [ERR_W-1:0]          err;
  logic [ERR_W-1:0]          prev_err;
  logic [INTEG_W-1:0]        integ;
  logic [DERIV_W-1:0]        deriv;
  logic signed [PROD_W-1:0]  prod;
  logic [ADJ_W-1:0]          acc;

  logic                      on_line;
  logic [CNT_W:0]            shifted;
  logic                      q_bit;
  logic [31:0]               diff;
  logic [ERR_W-1:0]          err_new;
  logic [GAIN_W-1:0]         mul_gain;
  logic [INTEG_W-1:0]        mul_op;
  logic signed [PROD_W-1:0]  prod_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RESET;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr    <= cfg_data[THR_W-1:0];
        REG_GAIN_P:    gain_p <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold compare on the sensor at the bottom of the shift line
  assign on_line = CMP_W'(shreg[SAMPLE_BITS-1:0]) >= CMP_W'(thr);

  // one restoring divide step
  assign shifted = {rem, quo[SUM_W-1]};
  assign q_bit   = shifted >= {1'b0, count};

  // position error from the quotient, kept to 13 bits
  assign diff    = 32'(LINE_GOAL) - 32'(quo);
  assign err_new = diff[ERR_W-1:0];

  // shared multiplier operand select
  always_comb begin
    case (cmd.term)
      TERM_P: begin
        mul_gain = gain_p;
        mul_op   = {{(INTEG_W-ERR_W){err[ERR_W-1]}}, err};
      end
      TERM_D: begin
        mul_gain = gain_d;
        mul_op   = {{(INTEG_W-DERIV_W){deriv[DERIV_W-1]}}, deriv};
      end
      TERM_I: begin
        mul_gain = gain_i;
        mul_op   = integ;
      end
      default: begin
        mul_gain = '0;
        mul_op   = '0;
      end
    endcase
  end

  assign prod_next = $signed({1'b0, mul_gain}) * $signed(mul_op);

  // scan, divide and multiply datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shreg  <= in_data[IN_W-1:0];
      weight <= SUM_W'(WEIGHT_STEP);
      sum    <= '0;
      count  <= '0;
    end
    if (cmd.scan) begin
      shreg  <= shreg >> SAMPLE_BITS;
      weight <= weight + SUM_W'(WEIGHT_STEP);
      if (on_line) begin
        sum   <= sum + weight;
        count <= count + 1'b1;
      end
    end
    if (cmd.div_init) begin
      quo <= sum;
      rem <= '0;
      acc <= '0;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? CNT_W'(shifted - {1'b0, count}) : shifted[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], q_bit};
    end
    if (cmd.update) begin
      err   <= err_new;
      deriv <= {err_new[ERR_W-1], err_new} - {prev_err[ERR_W-1], prev_err};
    end
    if (cmd.mul) begin
      if (cmd.term != TERM_ACC) begin
        prod <= prod_next;
      end
      if (cmd.term != TERM_P) begin
        acc <= acc + {prod[PROD_W-1], prod};
      end
    end
  end

  // kept loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else if (cmd.update) begin
      prev_err <= err_new;
      integ    <= integ + {{(INTEG_W-ERR_W){err_new[ERR_W-1]}}, err_new};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (count == '0) begin
        out_data <= '0;
        out_user <= 1'b1;
      end else begin
        out_data <= {{OUT_PAD_W{1'b0}}, err, acc};
        out_user <= 1'b0;
      end
    end
  end

  assign stat.count_zero = count == '0;
  assign stat.out_full   = out_valid;

endmodule

`default_nettype wire

### sv/lcp_ctrl.sv
`default_nettype none

module lcp_ctrl #(
  parameter int NUM_SENSORS = 9,
  parameter int DIV_STEPS   = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    out_ready,
  input  wire lcp_pkg::lcp_stat_t stat,
  output lcp_pkg::lcp_cmd_t      cmd
);
  import lcp_pkg::*;

  localparam int CTR_MAX = (NUM_SENSORS > DIV_STEPS) ? NUM_SENSORS : DIV_STEPS;
  localparam int CTR_W   = $clog2(CTR_MAX + 1);

  lcp_state_t       state;
  lcp_state_t       state_next;
  logic [CTR_W-1:0] cnt;
  logic             out_free;

  assign out_free = !stat.out_full || out_ready;

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN:   if (cnt == CTR_W'(NUM_SENSORS - 1)) state_next = S_CHECK;
      S_CHECK:  state_next = stat.count_zero ? S_FIN : S_DIV;
      S_DIV:    if (cnt == CTR_W'(DIV_STEPS - 1)) state_next = S_UPDATE;
      S_UPDATE: state_next = S_MUL;
      S_MUL:    if (cnt[1:0] == TERM_ACC) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.term     = mul_term_t'(cnt[1:0]);
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:   cmd.scan     = 1'b1;
      S_CHECK:  cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_UPDATE: cmd.update   = 1'b1;
      S_MUL:    cmd.mul      = 1'b1;
      S_FIN:    cmd.fin      = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/lcp_check.sv
`default_nettype none

module lcp_check (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire        m_axis_tuser,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no-line result carries zero error and zero correction
  a_no_line_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("no-line result not zero");

  // one scan at a time: busy right after taking a beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a beat");

  // a result never appears the cycle after a beat is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // nothing valid on the output after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind line_centroid_pid lcp_check u_lcp_check (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

`default_nettype wire

### sim/line_centroid_pid_checker.sv
`timescale 1ns / 1ps

module line_centroid_pid_checker #(
  parameter int NUM_SENSORS = 9,
  parameter int SAMPLE_BITS = 12,
  parameter int SCAN_W      = ((NUM_SENSORS*SAMPLE_BITS+7)/8)*8
) (
  input  wire                            clk,
  input  wire                            rst,
  // sample_0 .. sample_8, SAMPLE_BITS each, zero pad to bytes
  input  wire [SCAN_W-1:0]               s_axis_tdata,
  input  wire                            s_axis_tvalid,
  input  wire                            s_axis_tready,
  // drive_adjust [33:0], position_error [46:34], one zero bit
  input  wire [lcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // no_line
  input  wire                            m_axis_tuser,
  input  wire                            m_axis_tvalid,
  input  wire                            m_axis_tready,
  input  wire                            cfg_valid,
  input  wire                            cfg_ready,
  input  wire [lcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [lcp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             pending,
  output int                             mismatches
);
  import lcp_pkg::*;

  typedef struct {
    longint drive;
    longint pos_err;
    bit     no_line;
  } correction_t;

  // corrections predicted for accepted scans, oldest first
  correction_t correction_queue[$];

  // shadow copy of the registers and the loop state
  logic [THR_W-1:0]          threshold;
  longint                    kp;
  longint                    ki;
  longint                    kd;
  logic signed [ERR_W-1:0]   last_err;
  logic signed [INTEG_W-1:0] err_sum;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // centroid of the sensors on the line, then the pid sum on the wrapped error
  function automatic correction_t predict_correction(input logic [SCAN_W-1:0] scan);
    correction_t             c;
    int unsigned             wsum;
    int unsigned             hits;
    int                      i;
    logic [SAMPLE_BITS-1:0]  smp;
    logic signed [ERR_W-1:0] e;
    longint                  acc;
    wsum = 0;
    hits = 0;
    for (i = 0; i < NUM_SENSORS; i++) begin
      smp = scan[i*SAMPLE_BITS +: SAMPLE_BITS];
      if (smp >= threshold) begin
        wsum += WEIGHT_STEP * (i + 1);
        hits++;
      end
    end
    // no line seen: zero outputs, state untouched
    if (hits == 0) begin
      c.drive   = 0;
      c.pos_err = 0;
      c.no_line = 1'b1;
      return c;
    end
    e       = ERR_W'(LINE_GOAL - int'(wsum / hits));
    err_sum = err_sum + e;
    // derivative against the error of the last scan that saw the line
    acc = kp * longint'(e) + kd * (longint'(e) - longint'(last_err))
        + ki * longint'(err_sum);
    last_err  = e;
    c.drive   = longint'($signed(acc[ADJ_W-1:0]));
    c.pos_err = longint'(e);
    c.no_line = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    correction_t want;
    longint      got_drive;
    longint      got_err;
    if (rst) begin
      threshold = THR_RESET;
      kp        = 0;
      ki        = 0;
      kd        = 0;
      last_err  = '0;
      err_sum   = '0;
      correction_queue.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          REG_GAIN_P:    kp = longint'(cfg_data);
          REG_GAIN_I:    ki = longint'(cfg_data);
          REG_GAIN_D:    kd = longint'(cfg_data);
          default: ;
        endcase
      end
      // scan beat in
      if (s_axis_tvalid && s_axis_tready)
        correction_queue.push_back(predict_correction(s_axis_tdata));
      // result beat out
      if (m_axis_tvalid && m_axis_tready) begin
        got_drive = longint'($signed(m_axis_tdata[ADJ_W-1:0]));
        got_err   = longint'($signed(m_axis_tdata[ADJ_W +: ERR_W]));
        if (correction_queue.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, drive_adjust", 0, got_drive);
        end else begin
          want = correction_queue.pop_front();
          if (got_drive != want.drive)
            report_mismatch("drive_adjust", want.drive, got_drive);
          if (got_err != want.pos_err)
            report_mismatch("position_error", want.pos_err, got_err);
          if (m_axis_tuser != want.no_line)
            report_mismatch("no_line", longint'(want.no_line), longint'(m_axis_tuser));
        end
      end
    end
    pending <= correction_queue.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lcp_pkg::*;

  localparam int NUM_SENSORS   = 9;
  localparam int SAMPLE_BITS   = 12;
  localparam int SCAN_W        = ((NUM_SENSORS*SAMPLE_BITS+7)/8)*8;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE        = 40;
  localparam longint CYCLE_LIMIT = 400000;

  localparam logic [SCAN_W-1:0] FULL_SCAN = SCAN_W'({NUM_SENSORS*SAMPLE_BITS{1'b1}});

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  // sample_0 .. sample_8, 12 bits each, zero pad to bytes
  logic [SCAN_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  // drive_adjust [33:0], position_error [46:34], one zero bit
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;
  // no_line
  wire                    m_axis_tuser;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  wire                    cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int                     pending;
  int                     mismatches;
  longint                 cycles = 0;
  logic                   steady = 1'b0;
  logic [THR_W-1:0]       thr_now = THR_RESET;

  line_centroid_pid dut (.*);

  line_centroid_pid_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("line_centroid_pid: mismatch");
      $finish;
    end
  end

  // result side stalls
  always @(posedge clk)
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);

  // sensors in on_mask read at or above the threshold, the rest below it unless it is zero
  function automatic logic [SCAN_W-1:0] make_scan(input logic [NUM_SENSORS-1:0] on_mask,
                                                  input bit at_bound);
    logic [SCAN_W-1:0]      scan;
    logic [SAMPLE_BITS-1:0] smp;
    int                     i;
    scan = '0;
    for (i = 0; i < NUM_SENSORS; i++) begin
      if (on_mask[i] || thr_now == 0)
        smp = at_bound ? thr_now : SAMPLE_BITS'($urandom_range(thr_now, SAMPLE_MAX));
      else
        smp = at_bound ? SAMPLE_BITS'(thr_now - 1'b1)
                       : SAMPLE_BITS'($urandom_range(0, thr_now - 1));
      scan[i*SAMPLE_BITS +: SAMPLE_BITS] = smp;
    end
    return scan;
  endfunction

  // one scan beat, with random idle cycles ahead of it
  task automatic send_scan(input logic [SCAN_W-1:0] scan);
    while (!steady && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= scan;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // wait for the block to drain, then load all registers
  task automatic program_regs(input logic [THR_W-1:0] thr, input logic [GAIN_W-1:0] gp,
                              input logic [GAIN_W-1:0] gi, input logic [GAIN_W-1:0] gd);
    logic [CFG_DATA_W-1:0] val;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // junk in the unused upper bits of the threshold write
    val = CFG_DATA_W'($urandom);
    val[THR_W-1:0] = thr;
    write_reg(REG_THRESHOLD, val);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    // index past the register map, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    thr_now = thr;
  endtask

  initial begin
    logic [NUM_SENSORS-1:0] mask;
    logic [SCAN_W-1:0]      noise;
    logic [THR_W-1:0]       thr;
    logic [GAIN_W-1:0]      gp;
    logic [GAIN_W-1:0]      gi;
    logic [GAIN_W-1:0]      gd;
    int                     center;
    int                     width;
    int                     phase;
    int                     n;
    int                     r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: default threshold, zero gains
    send_scan(make_scan(NUM_SENSORS'(9'h010), 1'b0));
    send_scan(make_scan(NUM_SENSORS'(9'h001), 1'b1));

    // small gains, every sensor alone at the threshold, truncating centroids
    program_regs(12'd1000, 16'd3, 16'd2, 16'd5);
    send_scan('0);
    send_scan(FULL_SCAN);
    for (n = 0; n < NUM_SENSORS; n++)
      send_scan(make_scan(NUM_SENSORS'(1) << n, 1'b1));
    send_scan(make_scan(NUM_SENSORS'(9'h003), 1'b0));
    send_scan(make_scan(NUM_SENSORS'(9'h00B), 1'b0));
    send_scan(make_scan(NUM_SENSORS'(9'h180), 1'b0));
    send_scan(make_scan('0, 1'b0));

    // full gains, one edge sensor held until the integral wraps
    program_regs(12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (9) send_scan(make_scan(NUM_SENSORS'(9'h001), 1'b0));

    // random phases: a line drifting across the array, plus noise and lost line
    center = NUM_SENSORS / 2;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      thr = THR_W'($urandom);
      gp  = GAIN_W'($urandom);
      gi  = GAIN_W'($urandom);
      gd  = GAIN_W'($urandom);
      case (phase)
        0: thr = '0;
        1: begin
          thr = '1;
          gp  = '1;
          gi  = '1;
          gd  = '1;
        end
        2: begin
          gp = '0;
          gi = '0;
          gd = '0;
        end
        3: begin
          thr = THR_RESET;
          gp  = GAIN_W'($urandom_range(0, 255));
          gi  = GAIN_W'($urandom_range(0, 15));
          gd  = GAIN_W'($urandom_range(0, 255));
        end
        default: ;
      endcase
      program_regs(thr, gp, gi, gd);
      steady <= (phase == 5);
      for (n = 0; n < (phase == 0 ? 40 : PHASE_ITEMS); n++) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          width  = $urandom_range(1, 3);
          center = center + int'($urandom_range(0, 2)) - 1;
          if (center < 0) center = 0;
          if (center > NUM_SENSORS - 1) center = NUM_SENSORS - 1;
          mask = NUM_SENSORS'(((1 << width) - 1) << center);
          send_scan(make_scan(mask, 1'b0));
        end else if (r < 87) begin
          send_scan(make_scan(NUM_SENSORS'($urandom), 1'b0));
        end else if (r < 94) begin
          noise = SCAN_W'({$urandom, $urandom, $urandom, $urandom});
          noise[SCAN_W-1:NUM_SENSORS*SAMPLE_BITS] = '0;
          send_scan(noise);
        end else begin
          send_scan(make_scan('0, 1'b0));
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then a quiet tail to catch stray beats
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("line_centroid_pid: match");
    else
      $display("line_centroid_pid: mismatch");
    $finish;
  end

endmodule
